/* rtl/cfri_pkg.sv */
// ----------------------------------------------------------------------------
// cfri_pkg
// Shared types and constants for the cube face ray intersection pipeline.
// ----------------------------------------------------------------------------
package cfri_pkg;

  // Fraction bits of the face coordinates
  localparam int unsigned CoordFracBits = 16;
  localparam int unsigned CoordW        = 17;

  // Saturated "one" value, masked to the coordinate field
  localparam logic [CoordW-1:0] CoordOne =
      CoordW'((64'd1 << CoordFracBits) & 64'h1FFFF);

  // Configuration register indexes
  localparam logic [1:0] RegCenterX = 2'd0;
  localparam logic [1:0] RegCenterY = 2'd1;
  localparam logic [1:0] RegCenterZ = 2'd2;
  localparam logic [1:0] RegSize    = 2'd3;

  // Face codes
  localparam logic [2:0] FaceUp    = 3'd0;
  localparam logic [2:0] FaceDown  = 3'd1;
  localparam logic [2:0] FaceLeft  = 3'd2;
  localparam logic [2:0] FaceRight = 3'd3;
  localparam logic [2:0] FaceBack  = 3'd4;
  localparam logic [2:0] FaceFront = 3'd5;

  // One entry of the coordinate divider pipeline
  typedef struct packed {
    logic [2:0]               face;
    logic                     miss;
    logic                     sat_i;
    logic                     sat_j;
    logic [63:0]              m;
    logic [63:0]              r_i;
    logic [63:0]              r_j;
    logic [CoordFracBits-1:0] q_i;
    logic [CoordFracBits-1:0] q_j;
  } div_t;

endpackage

/* rtl/cube_face_ray_intersect.sv */
// ----------------------------------------------------------------------------
// cube_face_ray_intersect
// Finds the face of a configured axis-aligned cube that a ray meets and the
// normalized position of the hit point on that face.
// ----------------------------------------------------------------------------
// One ray enters per clock while the output does not stall, and one result
// leaves per ray, in order. Five stages form the per-axis hit tests exactly
// (set up, multiply, add, range check, face select), and one restoring
// divider stage per coordinate bit forms both coordinates.
// Every stage moves on its own as soon as the next one has room, so bubbles
// collapse and a stall at the output only backs up what is behind it. The
// faces are tried front, back, up, down, right, left; a face counts only when
// the direction along its axis has the face's sign, and its rectangle is
// widened by one LSB on each side. A ray that hits nothing returns miss with
// face and coordinates zero. Write configuration only while the block is
// empty; cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module cube_face_ray_intersect (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  // ray input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
  input  logic [191:0] s_axis_tdata,
  // result output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // face[2:0], coord_i[19:3], coord_j[36:20], zero pad [39:37]
  output logic [39:0]  m_axis_tdata,
  // miss
  output logic         m_axis_tuser
);
  import cfri_pkg::*;

  localparam int unsigned F = CoordFracBits;

  // Configuration registers
  logic signed [31:0] ctr_q [3];
  logic        [30:0] size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q[0] <= '0;
      ctr_q[1] <= '0;
      ctr_q[2] <= '0;
      size_q   <= 31'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegCenterX: ctr_q[0] <= cfg_data_i;
        RegCenterY: ctr_q[1] <= cfg_data_i;
        RegCenterZ: ctr_q[2] <= cfg_data_i;
        RegSize:    size_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or the next one loads
  logic va_q, vb_q, vc_q, vd_q, ve_q;
  logic en_a, en_b, en_c, en_d, en_e;
  logic [F-1:0] vdiv_q;
  logic [F:0]   en_div;

  assign en_div[F] = !vdiv_q[F-1] || m_axis_tready;
  for (genvar k = 0; k < F; k++) begin : g_en
    assign en_div[k] = !vdiv_q[k] || en_div[k+1];
  end
  assign en_e = !ve_q || en_div[0];
  assign en_d = !vd_q || en_e;
  assign en_c = !vc_q || en_d;
  assign en_b = !vb_q || en_c;
  assign en_a = !va_q || en_b;
  assign s_axis_tready = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      vc_q   <= 1'b0;
      vd_q   <= 1'b0;
      ve_q   <= 1'b0;
      vdiv_q <= '0;
    end else begin
      if (en_a) va_q <= s_axis_tvalid;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
      if (en_d) vd_q <= vc_q;
      if (en_e) ve_q <= vd_q;
      for (int k = 0; k < F; k++) begin
        if (en_div[k]) vdiv_q[k] <= (k == 0) ? ve_q : vdiv_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Coordinate axes of the faces on each axis: x faces use (z, y),
  // y faces use (x, z), z faces use (x, y).
  localparam int CoordAxis0 [3] = '{2, 0, 0};
  localparam int CoordAxis1 [3] = '{1, 2, 1};

  // ---------------------------------------------------------------- stage A
  // Geometry in half-LSB units: position doubled, bounds widened by eps.
  logic signed [31:0] dir_a_q  [3];
  logic        [31:0] den_a_q  [3];
  logic signed [34:0] dist_a_q [3];
  logic signed [34:0] rel_a_q  [3];

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [31:0] org, dir;
        logic signed [32:0] pos, c2;
        logic signed [33:0] lo, hi;
        org = s_axis_tdata[32*k +: 32];
        dir = s_axis_tdata[32*(k+3) +: 32];
        pos = {org, 1'b0};
        c2  = {ctr_q[k], 1'b0};
        lo  = $signed({c2[32], c2}) - $signed({3'b000, size_q}) - 34'sd2;
        hi  = $signed({c2[32], c2}) + $signed({3'b000, size_q}) + 34'sd2;
        dir_a_q[k] <= dir;
        den_a_q[k] <= dir[31] ? (~dir + 32'd1) : dir;
        rel_a_q[k] <= $signed({{2{pos[32]}}, pos}) - $signed({lo[33], lo});
        // Distance to the face plane that the direction sign selects
        if (dir[31]) begin
          dist_a_q[k] <= $signed({{2{pos[32]}}, pos}) - $signed({lo[33], lo});
        end else begin
          dist_a_q[k] <= $signed({hi[33], hi}) - $signed({{2{pos[32]}}, pos});
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage B
  // Products: numerator = rel * den + dir * dist, per axis and coordinate.
  logic signed [67:0] p1_b_q  [3][2];
  logic signed [66:0] p2_b_q  [3][2];
  logic        [64:0] span_b_q[3];
  logic        [63:0] m_b_q   [3];
  logic        [1:0]  sgn_b_q [3];   // {positive, negative}

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      for (int a = 0; a < 3; a++) begin
        p1_b_q[a][0] <= rel_a_q[CoordAxis0[a]] * $signed({1'b0, den_a_q[a]});
        p1_b_q[a][1] <= rel_a_q[CoordAxis1[a]] * $signed({1'b0, den_a_q[a]});
        p2_b_q[a][0] <= dir_a_q[CoordAxis0[a]] * dist_a_q[a];
        p2_b_q[a][1] <= dir_a_q[CoordAxis1[a]] * dist_a_q[a];
        span_b_q[a]  <= ({1'b0, size_q, 1'b0} + 33'd4) * den_a_q[a];
        m_b_q[a]     <= {size_q, 1'b0} * den_a_q[a];
        sgn_b_q[a]   <= {!dir_a_q[a][31] && (dir_a_q[a] != '0), dir_a_q[a][31]};
      end
    end
  end

  // ---------------------------------------------------------------- stage C
  logic signed [68:0] n_c_q   [3][2];
  logic        [64:0] span_c_q[3];
  logic        [63:0] m_c_q   [3];
  logic        [1:0]  sgn_c_q [3];

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      for (int a = 0; a < 3; a++) begin
        for (int c = 0; c < 2; c++) begin
          n_c_q[a][c] <= $signed({p1_b_q[a][c][67], p1_b_q[a][c]})
                       + $signed({{2{p2_b_q[a][c][66]}}, p2_b_q[a][c]});
        end
        span_c_q[a] <= span_b_q[a];
        m_c_q[a]    <= m_b_q[a];
        sgn_c_q[a]  <= sgn_b_q[a];
      end
    end
  end

  // ---------------------------------------------------------------- stage D
  // Range check: the hit point lies on the widened face when 0 <= n <= span.
  logic [64:0] n_d_q  [3][2];
  logic [63:0] m_d_q  [3];
  logic [1:0]  sgn_d_q[3];
  logic [2:0]  hit_d_q;

  always_ff @(posedge clk_i) begin
    if (en_d) begin
      for (int a = 0; a < 3; a++) begin
        logic ok;
        ok = sgn_c_q[a] != 2'b00;
        for (int c = 0; c < 2; c++) begin
          if (n_c_q[a][c] < 0) ok = 1'b0;
          if (n_c_q[a][c] > $signed({4'b0000, span_c_q[a]})) ok = 1'b0;
          n_d_q[a][c] <= n_c_q[a][c][64:0];
        end
        hit_d_q[a] <= ok;
        m_d_q[a]   <= m_c_q[a];
        sgn_d_q[a] <= sgn_c_q[a];
      end
    end
  end

  // ---------------------------------------------------------------- stage E
  // Pick the first hit face in priority order z, y, x and set up the divider.
  div_t div_e_q;

  always_ff @(posedge clk_i) begin
    if (en_e) begin
      logic [1:0]  ax;
      logic [2:0]  fc;
      logic        miss;
      logic [64:0] ni, nj;
      logic [63:0] m;
      div_t        nxt;
      miss = 1'b0;
      ax   = 2'd0;
      fc   = '0;
      if (hit_d_q[2]) begin
        ax = 2'd2;
        fc = sgn_d_q[2][1] ? FaceFront : FaceBack;
      end else if (hit_d_q[1]) begin
        ax = 2'd1;
        fc = sgn_d_q[1][1] ? FaceUp : FaceDown;
      end else if (hit_d_q[0]) begin
        ax = 2'd0;
        fc = sgn_d_q[0][1] ? FaceRight : FaceLeft;
      end else begin
        miss = 1'b1;
      end
      ni = n_d_q[ax][0];
      nj = n_d_q[ax][1];
      m  = m_d_q[ax];
      nxt.face  = fc;
      nxt.miss  = miss;
      nxt.sat_i = ni >= {1'b0, m};
      nxt.sat_j = nj >= {1'b0, m};
      nxt.m     = m;
      nxt.r_i   = ni[63:0];
      nxt.r_j   = nj[63:0];
      nxt.q_i   = '0;
      nxt.q_j   = '0;
      div_e_q  <= nxt;
    end
  end

  // ---------------------------------------------------------- divider stages
  // Restoring division, one quotient bit of each coordinate per stage.
  div_t div_q [F];

  for (genvar k = 0; k < F; k++) begin : g_div
    div_t src;
    assign src = (k == 0) ? div_e_q : div_q[(k == 0) ? 0 : k-1];

    always_ff @(posedge clk_i) begin
      if (en_div[k]) begin
        logic [64:0] ri, rj;
        logic        gi, gj;
        div_t        nxt;
        ri = {src.r_i, 1'b0};
        rj = {src.r_j, 1'b0};
        gi = ri >= {1'b0, src.m};
        gj = rj >= {1'b0, src.m};
        nxt     = src;
        nxt.r_i = gi ? 64'(ri - {1'b0, src.m}) : ri[63:0];
        nxt.r_j = gj ? 64'(rj - {1'b0, src.m}) : rj[63:0];
        nxt.q_i = {src.q_i[F-2:0], gi};
        nxt.q_j = {src.q_j[F-2:0], gj};
        div_q[k] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------- output
  div_t             fin;
  logic [CoordW-1:0] coord_i, coord_j;
  logic [2:0]        face;

  assign fin     = div_q[F-1];
  assign face    = fin.miss ? 3'd0 : fin.face;
  assign coord_i = fin.miss ? '0 : (fin.sat_i ? CoordOne : CoordW'(fin.q_i));
  assign coord_j = fin.miss ? '0 : (fin.sat_j ? CoordOne : CoordW'(fin.q_j));

  assign m_axis_tvalid = vdiv_q[F-1];
  assign m_axis_tdata  = {3'b000, coord_j, coord_i, face};
  assign m_axis_tuser  = fin.miss;

endmodule

/* tb/sv/tb_cube_face_ray_intersect.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cube_face_ray_intersect
// Self-checking bench for the cube face ray intersection pipeline. Rays are
// streamed in bursts against several cube settings, each result is predicted
// with exact wide integer arithmetic and compared field by field in order.
// ----------------------------------------------------------------------------
module tb_cube_face_ray_intersect;
  import cfri_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 60;

  typedef struct packed {
    logic signed [31:0] dz, dy, dx, oz, oy, ox;
  } ray_t;

  typedef struct packed {
    logic        miss;
    logic [16:0] cj;
    logic [16:0] ci;
    logic [2:0]  face;
  } hit_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i;
  logic [31:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z from bit 0 up
  logic [191:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // face, coord_i, coord_j, zero pad from bit 0 up
  logic [39:0]  m_axis_tdata;
  // miss
  logic         m_axis_tuser;

  cube_face_ray_intersect DUT (.*);

  // Shadow copy of the cube registers
  logic signed [31:0] cube_ctr [3];
  logic [30:0]        cube_edge;

  ray_t ray_q [$];
  hit_t hit_q [$];
  int   errors;
  int   idle_cycles;
  bit   hold_input;
  int   hold_output;

  // -------------------------------------------------------------------------
  // Predictor: exact rational hit test with 192-bit signed products.
  // All lengths are held in half-LSB units so that size/2 stays integral.
  // -------------------------------------------------------------------------
  function automatic logic [16:0] face_coord(logic signed [191:0] num,
                                             logic signed [191:0] m);
    logic [191:0] r;
    logic [16:0]  q;
    q = '0;
    if (num >= m) return CoordOne;
    r = num;
    for (int k = 0; k < CoordFracBits; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= m) begin
        r = r - m;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic bit probe_face(int a, bit pos, int ci, int cj,
                                    logic signed [191:0] p[3],
                                    logic signed [191:0] d[3],
                                    logic signed [191:0] lo[3],
                                    logic signed [191:0] hi[3],
                                    output logic [16:0] oi,
                                    output logic [16:0] oj);
    logic signed [191:0] den, plane_dist, span, ni, nj, m;
    oi = '0;
    oj = '0;
    if (pos ? d[a] <= 0 : d[a] >= 0) return 0;
    den  = d[a] < 0 ? -d[a] : d[a];
    plane_dist = pos ? hi[a] - p[a] : p[a] - lo[a];
    span = (2 * $signed({161'd0, cube_edge}) + 4) * den;
    ni = (p[ci] - lo[ci]) * den + d[ci] * plane_dist;
    nj = (p[cj] - lo[cj]) * den + d[cj] * plane_dist;
    if (ni < 0 || ni > span || nj < 0 || nj > span) return 0;
    m  = 2 * $signed({161'd0, cube_edge}) * den;
    oi = face_coord(ni, m);
    oj = face_coord(nj, m);
    return 1;
  endfunction

  function automatic hit_t trace_ray(ray_t r);
    logic signed [191:0] p[3], d[3], lo[3], hi[3];
    logic signed [31:0]  o[3], v[3];
    logic [16:0] ci, cj;
    hit_t h;
    o = '{r.ox, r.oy, r.oz};
    v = '{r.dx, r.dy, r.dz};
    for (int k = 0; k < 3; k++) begin
      p[k]  = 2 * 192'(o[k]);
      d[k]  = 192'(v[k]);
      lo[k] = 2 * 192'(cube_ctr[k]) - $signed({161'd0, cube_edge}) - 2;
      hi[k] = 2 * 192'(cube_ctr[k]) + $signed({161'd0, cube_edge}) + 2;
    end
    h = '0;
    if (probe_face(2, 1, 0, 1, p, d, lo, hi, ci, cj)) h.face = FaceFront;
    else if (probe_face(2, 0, 0, 1, p, d, lo, hi, ci, cj)) h.face = FaceBack;
    else if (probe_face(1, 1, 0, 2, p, d, lo, hi, ci, cj)) h.face = FaceUp;
    else if (probe_face(1, 0, 0, 2, p, d, lo, hi, ci, cj)) h.face = FaceDown;
    else if (probe_face(0, 1, 2, 1, p, d, lo, hi, ci, cj)) h.face = FaceRight;
    else if (probe_face(0, 0, 2, 1, p, d, lo, hi, ci, cj)) h.face = FaceLeft;
    else begin
      h.miss = 1'b1;
      ci = '0;
      cj = '0;
    end
    h.ci = ci;
    h.cj = cj;
    return h;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // Append a ray to the pending queue
  function automatic void add_ray(ray_t r);
    ray_q = {ray_q, r};
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // -------------------------------------------------------------------------
  // Driver: pull rays from ray_q, in bursts separated by random gaps
  // -------------------------------------------------------------------------
  int burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      // Predict the ray that moved on this edge and drop it from the queue
      if (s_axis_tvalid && s_axis_tready) begin
        hit_q = {hit_q, trace_ray(ray_t'(s_axis_tdata))};
        void'(ray_q.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the offered ray
      end else if (gap_left > 0 || hold_input || ray_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ray_q[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor and output backpressure
  // -------------------------------------------------------------------------
  int stall_mode;
  always @(posedge clk_i or negedge rst_ni) begin
    hit_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      idle_cycles   <= 0;
      stall_mode    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = hit_t'({m_axis_tuser, m_axis_tdata[36:0]});
        if (hit_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(got), 64'd0);
        end else begin
          want = hit_q.pop_front();
          if (got.face != want.face)
            report_mismatch("face", 64'(got.face), 64'(want.face));
          if (got.ci != want.ci) report_mismatch("coord_i", 64'(got.ci), 64'(want.ci));
          if (got.cj != want.cj) report_mismatch("coord_j", 64'(got.cj), 64'(want.cj));
          if (got.miss != want.miss)
            report_mismatch("miss", 64'(got.miss), 64'(want.miss));
          if (m_axis_tdata[39:37] != 3'd0)
            report_mismatch("pad", 64'(m_axis_tdata[39:37]), 64'd0);
        end
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end
      // Stall pattern: switch between free flow, a mostly-ready pattern and a sparse ready pattern
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
      if (hold_output > 0) begin
        hold_output   <= hold_output - 1;
        m_axis_tready <= 1'b0;
      end else
        m_axis_tready <= stall_mode == 0 ? 1'b1 :
                         stall_mode == 1 ? ($urandom_range(0, 3) != 0) :
                                           ($urandom_range(0, 3) == 0);
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegCenterX: cube_ctr[0] = val;
      RegCenterY: cube_ctr[1] = val;
      RegCenterZ: cube_ctr[2] = val;
      default:    cube_edge   = val[30:0];
    endcase
  endtask

  // Wait until every queued ray was accepted and answered
  task automatic drain();
    while (ray_q.size() != 0 || s_axis_tvalid || hit_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom();
    endcase
  endfunction

  // Ray that aims at a point close to the cube, seen from a random origin
  function automatic ray_t aimed_ray(int span);
    ray_t r;
    logic signed [31:0] tgt[3];
    int sc;
    for (int k = 0; k < 3; k++)
      tgt[k] = cube_ctr[k] + $signed(32'(int'($urandom_range(0, 2 * span)) - span));
    r.ox = tgt[0] + $signed(32'(int'($urandom_range(0, 8 * span)) - 4 * span));
    r.oy = tgt[1] + $signed(32'(int'($urandom_range(0, 8 * span)) - 4 * span));
    r.oz = tgt[2] + $signed(32'(int'($urandom_range(0, 8 * span)) - 4 * span));
    sc = $urandom_range(0, 3);
    r.dx = (tgt[0] - r.ox) >>> sc;
    r.dy = (tgt[1] - r.oy) >>> sc;
    r.dz = (tgt[2] - r.oz) >>> sc;
    if ($urandom_range(0, 5) == 0) r.dx = 0;
    if ($urandom_range(0, 5) == 0) r.dy = 0;
    return r;
  endfunction

  function automatic ray_t noise_ray();
    return '{rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word()};
  endfunction

  function automatic ray_t mk(int ox, int oy, int oz, int dx, int dy, int dz);
    return '{dz, dy, dx, oz, oy, ox};
  endfunction

  initial begin
    int span;
    errors      = 0;
    hold_input  = 0;
    hold_output = 0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    cube_ctr    = '{0, 0, 0};
    cube_edge   = 31'd65536;
    rst_ni      = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rays against the reset cube: each face, edges, zero direction
    add_ray(mk(0, 0, -65536 * 3, 0, 0, 1));
    add_ray(mk(0, 0, 65536 * 3, 0, 0, -1));
    add_ray(mk(0, -65536 * 3, 0, 0, 5, 0));
    add_ray(mk(0, 65536 * 3, 0, 0, -5, 0));
    add_ray(mk(-65536 * 3, 0, 0, 7, 0, 0));
    add_ray(mk(65536 * 3, 0, 0, -7, 0, 0));
    add_ray(mk(0, 0, 0, 0, 0, 0));
    add_ray(mk(32768, 32768, 0, 0, 0, 1));
    add_ray(mk(32769, -32769, 0, 0, 0, 1));
    add_ray(mk(32770, 0, 0, 0, 0, 1));
    add_ray(mk(-32769, 32769, 9, 0, 0, -3));
    add_ray(mk(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1));
    add_ray(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_ray(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    add_ray(mk(-1, -1, -1, -1, -1, -1));
    add_ray(mk(100000, 0, 0, -1, 0, 0));
    drain();

    // Phases: walk through several cube settings, extremes among them
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(RegCenterX, 0); write_reg(RegCenterY, 0);
          write_reg(RegCenterZ, 0); write_reg(RegSize, 32'd1);
        end
        1: begin
          write_reg(RegCenterX, 32'h7FFF_FFFF); write_reg(RegCenterY, 32'h8000_0000);
          write_reg(RegCenterZ, 32'd123456); write_reg(RegSize, 32'h7FFF_FFFF);
        end
        2: begin
          write_reg(RegCenterX, 32'h8000_0000); write_reg(RegCenterY, 32'h7FFF_FFFF);
          write_reg(RegCenterZ, 32'hFFFF_0000); write_reg(RegSize, 32'd0);
        end
        3: write_reg(RegSize, 32'hFFFF_FFFF);
        default: begin
          write_reg(RegCenterX, $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000);
          write_reg(RegCenterY, $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000);
          write_reg(RegCenterZ, $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000);
          write_reg(RegSize, $urandom_range(1, 32'h0008_0000));
        end
      endcase
      span = cube_edge > 2048 ? cube_edge / 2 + 4 : 4096;
      if (span > 32'h0100_0000) span = 32'h0100_0000;
      for (int n = 0; n < 115; n++)
        add_ray($urandom_range(0, 4) == 0 ? noise_ray() : aimed_ray(span));
      // Back up the pipe once with a long output stall
      if (ph == 1) begin
        while (ray_q.size() > 60) @(posedge clk_i);
        hold_output = 200;
      end
      drain();
    end

    // Pause until all results have come, then finish
    drain();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/cfri_pkg.sv
rtl/cube_face_ray_intersect.sv
tb/sv/tb_cube_face_ray_intersect.sv
